@@ hdl/alarm_table_timer_defines.svh @@
// Assertion helpers shared by the alarm table timer RTL.
`ifndef ALARM_TABLE_TIMER_DEFINES_SVH
`define ALARM_TABLE_TIMER_DEFINES_SVH

// Same-cycle implication.
`define ATT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alarm table timer: assertion failed");

// Next-cycle implication.
`define ATT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alarm table timer: assertion failed");

`endif

@@ hdl/att_pkg.sv @@
package att_pkg;

   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_SET    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   localparam logic KIND_FIRE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam int TIME_W = 16;

   typedef struct packed {
      logic [7:0]        handler;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] left;
      logic              repeats;
   } att_entry_type;

   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] quotient;
      logic [TIME_W-1:0] remainder;
   } att_div_result_type;

endpackage

@@ hdl/att_ram.sv @@
module att_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/att_div.sv @@
module att_div
   import att_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TIME_W-1:0]  dividend,
   input  logic [TIME_W-1:0]  divisor,
   output att_div_result_type result
);

   localparam int CNT_W = $clog2(TIME_W + 1);

   logic [TIME_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [TIME_W:0]   shifted;
   logic [TIME_W:0]   diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, quo_ff[TIME_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(TIME_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[TIME_W-2:0], ~diff[TIME_W]};
         rem_in = diff[TIME_W] ? shifted[TIME_W-1:0] : diff[TIME_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

@@ hdl/alarm_table_timer.sv @@
// Alarm table timer. An item is taken when start is high and busy is low; every
// item answers with fire results (tick only, table order) followed by exactly
// one status result with rsp_last set. Results appear for one cycle on
// rsp_valid and cannot be held off. Set, clear, and a tick or remove on an
// empty table are answered without leaving idle: the status shows in the next
// cycle and busy stays low. Tick and remove walk the table through its entry
// RAM (one read port, one write port), reading and then evaluating each slot
// below the entry count before giving the status; each expiring repeating
// alarm waits on the shared 16-step divider that works out its fire count and
// reload.
`include "alarm_table_timer_defines.svh"

module alarm_table_timer
   import att_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_handler_id,
   input  logic [15:0] req_interval,
   input  logic        req_repeat_req,
   input  logic [15:0] req_elapsed,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [7:0]  rsp_fired_handler,
   output logic [15:0] rsp_fire_count,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     wr_ff, wr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [1:0]        func_ff;
   logic [7:0]        hid_ff;
   logic [15:0]       el_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_hid_ff, rsp_hid_in;
   logic [15:0]       rsp_cnt_ff, rsp_cnt_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              ram_we;
   logic [IW-1:0]     ram_waddr;
   att_entry_type     ram_wdata;
   logic              ram_re;
   logic [$bits(att_entry_type)-1:0] ram_rdata;
   att_entry_type     rd;

   logic              div_start;
   att_div_result_type div_res;

   logic              expired;
   logic [15:0]       over;
   logic              step;
   logic              keep;
   logic [15:0]       keep_left;
   logic [CW-1:0]     wr_next;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign rd     = att_entry_type'(ram_rdata);

   assign expired = (el_ff >= rd.left);
   assign over    = el_ff - rd.left;

   att_ram #(
      .WIDTH($bits(att_entry_type)),
      .DEPTH(SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   att_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (over),
      .divisor  (rd.period),
      .result   (div_res)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_ff[IW-1:0];
      ram_wdata     = rd;
      ram_re        = 1'b0;
      div_start     = 1'b0;
      step          = 1'b0;
      keep          = 1'b0;
      keep_left     = rd.left;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_STATUS;
      rsp_hid_in    = '0;
      rsp_cnt_in    = '0;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_func) inside
                  FUNC_SET: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (req_interval == '0) begin
                        rsp_status_in = STATUS_ZERO;
                     end else if (count_ff == CW'(SLOTS)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ram_we            = 1'b1;
                        ram_waddr         = count_ff[IW-1:0];
                        ram_wdata.handler = req_handler_id;
                        ram_wdata.period  = req_interval;
                        ram_wdata.left    = req_interval;
                        ram_wdata.repeats = req_repeat_req;
                        valid_in[count_ff[IW-1:0]] = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FUNC_CLEAR: begin
                     valid_in     = '0;
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                  end
                  FUNC_TICK, FUNC_REMOVE: begin
                     idx_in = '0;
                     wr_in  = '0;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_last_in  = 1'b1;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            ram_re   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (func_ff == FUNC_REMOVE) begin
               step = 1'b1;
               if (valid_ff[idx_ff[IW-1:0]] && rd.handler == hid_ff) begin
                  valid_in[idx_ff[IW-1:0]] = 1'b0;
               end
            end else if (!valid_ff[idx_ff[IW-1:0]]) begin
               step = 1'b1;
            end else if (!expired) begin
               step      = 1'b1;
               keep      = 1'b1;
               keep_left = rd.left - el_ff;
            end else if (rd.repeats) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               // one-shot expiry: fire once, drop the entry
               step         = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FIRE;
               rsp_hid_in   = rd.handler;
               rsp_cnt_in   = 16'd1;
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               step         = 1'b1;
               keep         = 1'b1;
               keep_left    = rd.period - div_res.remainder;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FIRE;
               rsp_hid_in   = rd.handler;
               rsp_cnt_in   = div_res.quotient + 16'd1;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // compaction: kept entries slide down to the write index
      wr_next = wr_ff + CW'(keep);
      if (keep) begin
         ram_we         = 1'b1;
         ram_wdata      = rd;
         ram_wdata.left = keep_left;
         valid_in[wr_ff[IW-1:0]] = 1'b1;
      end
      if (step) begin
         wr_in = wr_next;
         if (idx_ff + CW'(1) == count_ff) begin
            state_in = S_DONE;
            if (func_ff == FUNC_TICK) begin
               count_in = wr_next;
               for (int k = 0; k < SLOTS; k++) begin
                  if (CW'(k) >= wr_next) begin
                     valid_in[k] = 1'b0;
                  end
               end
            end
         end else begin
            idx_in   = idx_ff + CW'(1);
            state_in = S_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         wr_ff        <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         wr_ff        <= wr_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         func_ff <= req_func;
         hid_ff  <= req_handler_id;
         el_ff   <= req_elapsed;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_hid_ff    <= rsp_hid_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_fired_handler = rsp_hid_ff;
   assign rsp_fire_count    = rsp_cnt_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

   `ATT_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CW'(SLOTS))
   `ATT_ASSERT_NOW(a_compact_order, clock, reset, state_ff == S_EVAL || state_ff == S_DIV, wr_ff <= idx_ff)
   `ATT_ASSERT_NOW(a_fire_on_tick, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_FIRE, func_ff == FUNC_TICK)
   `ATT_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid_ff)

endmodule

@@ dv/alarm_table_timer_tb.sv @@
`timescale 1ns / 100ps

module alarm_table_timer_tb
   import att_pkg::*;
();

   localparam int ALARM_SLOTS = 16;
   localparam int QUIET_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 410;

   typedef struct packed {
      logic        kind;
      logic [7:0]  handler;
      logic [15:0] count;
      logic [1:0]  status;
      logic        last;
   } alarm_result_type;

   // Shadow of the alarm table plus the queue of results still owed by the block.
   class alarm_ledger;
      att_entry_type slot[ALARM_SLOTS];
      bit live[ALARM_SLOTS];
      int used;
      int errors;
      alarm_result_type owed[$];

      function new();
         used = 0;
         errors = 0;
         foreach (live[i]) live[i] = 1'b0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void owe(alarm_result_type r);
         owed.insert(owed.size(), r);
      endfunction

      function void take_request(logic [1:0] func, logic [7:0] hid, logic [15:0] ival,
                                 logic rep, logic [15:0] el);
         int w;
         int unsigned over;
         int unsigned fires;
         bit keep;
         logic [1:0] st;
         st = STATUS_OK;
         case (func)
            FUNC_TICK: begin
               w = 0;
               for (int i = 0; i < used; i++) begin
                  if (live[i]) begin
                     keep = 1'b1;
                     if (el >= slot[i].left) begin
                        over = 32'(el - slot[i].left);
                        fires = 1;
                        if (slot[i].repeats) begin
                           fires = over / slot[i].period + 1;
                           slot[i].left = 16'(slot[i].period - over % slot[i].period);
                        end else begin
                           keep = 1'b0;
                        end
                        owe('{KIND_FIRE, slot[i].handler, fires[15:0], STATUS_OK, 1'b0});
                     end else begin
                        slot[i].left = slot[i].left - el;
                     end
                     if (keep) begin
                        slot[w] = slot[i];
                        live[w] = 1'b1;
                        w++;
                     end
                  end
               end
               for (int i = w; i < ALARM_SLOTS; i++) live[i] = 1'b0;
               used = w;
            end
            FUNC_SET: begin
               if (ival == 16'd0) begin
                  st = STATUS_ZERO;
               end else if (used >= ALARM_SLOTS) begin
                  st = STATUS_FULL;
               end else begin
                  slot[used] = '{hid, ival, ival, rep};
                  live[used] = 1'b1;
                  used++;
               end
            end
            FUNC_REMOVE: begin
               for (int i = 0; i < used; i++)
                  if (live[i] && slot[i].handler == hid) live[i] = 1'b0;
            end
            default: begin
               foreach (live[i]) live[i] = 1'b0;
               used = 0;
            end
         endcase
         owe('{KIND_STATUS, 8'd0, 16'd0, st, 1'b1});
      endfunction

      function void report(string field, logic [15:0] want_v, logic [15:0] got_v);
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
         errors++;
      endfunction

      function void match_result(alarm_result_type got);
         alarm_result_type want;
         if (owed.size() == 0) begin
            $display({"%0t: unexpected result, expected none, actual kind %0d",
                      " handler %0d count %0d status %0d last %0d"},
                     $time, got.kind, got.handler, got.count, got.status, got.last);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.kind !== want.kind) report("kind", 16'(want.kind), 16'(got.kind));
         if (got.handler !== want.handler)
            report("fired_handler", 16'(want.handler), 16'(got.handler));
         if (got.count !== want.count) report("fire_count", want.count, got.count);
         if (got.status !== want.status)
            report("status", 16'(want.status), 16'(got.status));
         if (got.last !== want.last) report("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_func;
   logic [7:0]  req_handler_id;
   logic [15:0] req_interval;
   logic        req_repeat_req;
   logic [15:0] req_elapsed;
   logic        rsp_valid;
   logic        rsp_kind;
   logic [7:0]  rsp_fired_handler;
   logic [15:0] rsp_fire_count;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   alarm_ledger ledger = new();
   bit sender_idles = 1'b1;
   int quiet_cycles = 0;

   alarm_table_timer #(.SLOTS(ALARM_SLOTS)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_handler_id    (req_handler_id),
      .req_interval      (req_interval),
      .req_repeat_req    (req_repeat_req),
      .req_elapsed       (req_elapsed),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fire_count    (rsp_fire_count),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Results and request transfers are both taken here so their order is fixed.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            ledger.match_result('{rsp_kind, rsp_fired_handler, rsp_fire_count,
                                  rsp_status, rsp_last});
         if (start && !busy)
            ledger.take_request(req_func, req_handler_id, req_interval,
                                req_repeat_req, req_elapsed);
         if (rsp_valid || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input logic [1:0] func, input logic [7:0] hid,
                            input logic [15:0] ival, input logic rep,
                            input logic [15:0] el);
      if (sender_idles)
         while ($urandom_range(99) < 16) begin
            start <= 1'b0;
            @(negedge clock);
         end
      start          <= 1'b1;
      req_func       <= func;
      req_handler_id <= hid;
      req_interval   <= ival;
      req_repeat_req <= rep;
      req_elapsed    <= el;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
   endtask

   initial begin
      logic [1:0]  f;
      logic [7:0]  h;
      logic [15:0] iv;
      logic        rp;
      logic [15:0] el;
      int unsigned pick;

      reset          <= 1'b1;
      start          <= 1'b0;
      req_func       <= FUNC_TICK;
      req_handler_id <= 8'd0;
      req_interval   <= 16'd0;
      req_repeat_req <= 1'b0;
      req_elapsed    <= 16'd0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, zero interval, extremes, exact expiry, full, clear
      send_item(FUNC_TICK, 8'd0, 16'd0, 1'b0, 16'd0);
      send_item(FUNC_SET, 8'd9, 16'd0, 1'b1, 16'd0);
      send_item(FUNC_SET, 8'd0, 16'd1, 1'b0, 16'd0);
      send_item(FUNC_SET, 8'd255, 16'hFFFF, 1'b1, 16'd0);
      send_item(FUNC_SET, 8'h55, 16'd3, 1'b1, 16'd0);
      send_item(FUNC_TICK, 8'd0, 16'd0, 1'b0, 16'd0);
      send_item(FUNC_TICK, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF);
      send_item(FUNC_REMOVE, 8'h55, 16'd0, 1'b0, 16'd0);
      // removed entry still holds its slot until the next tick
      for (int i = 0; i < 14; i++)
         send_item(FUNC_SET, 8'($urandom_range(255)), 16'd1, 1'b1, 16'd0);
      send_item(FUNC_SET, 8'hAA, 16'd7, 1'b0, 16'd0);
      send_item(FUNC_TICK, 8'd0, 16'd0, 1'b0, 16'hFFFF);
      send_item(FUNC_CLEAR, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF);
      wait_drained();

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == 150 || k == 300) wait_drained();
         sender_idles = !(k >= 200 && k < 280);
         f  = 2'($urandom);
         h  = 8'($urandom);
         iv = 16'($urandom);
         rp = 1'($urandom);
         el = 16'($urandom);
         // few handlers so removes find matches; short times so ticks expire alarms
         if ($urandom_range(3) != 0) h = 8'($urandom_range(7));
         pick = $urandom_range(99);
         if (pick < 45) begin
            f = FUNC_SET;
            pick = $urandom_range(9);
            if (pick < 8) iv = 16'($urandom_range(1, 40));
            else if (pick == 8) iv = 16'd0;
         end else if (pick < 78) begin
            f = FUNC_TICK;
            pick = $urandom_range(9);
            if (pick < 7) el = 16'($urandom_range(30));
            else if (pick < 9) el = 16'($urandom_range(200));
         end else if (pick < 94) begin
            f = FUNC_REMOVE;
         end else begin
            f = FUNC_CLEAR;
         end
         send_item(f, h, iv, rp, el);
      end

      start <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/att_pkg.sv
hdl/att_ram.sv
hdl/att_div.sv
hdl/alarm_table_timer.sv
dv/alarm_table_timer_tb.sv
